// File: rtl/core/fbt_pkg.sv
// Package for the flow bulk transfer tracker: beat types, the configuration
// and per-direction counter structs, register indexes and reset constants.
// No dependencies.
package fbt_pkg;

    typedef struct packed {
        logic        direction;
        logic [47:0] timestamp;
        logic [15:0] payload_bytes;
    } fbt_in_t;

    typedef struct packed {
        logic        direction_out;
        logic [31:0] bulks_done;
        logic [31:0] bulk_packets;
        logic [39:0] bulk_bytes;
        logic [47:0] bulk_time;
        logic        in_bulk;
    } fbt_out_t;

    typedef struct packed {
        logic [31:0] idle_limit;
        logic [7:0]  min_bulk_packets;
    } fbt_cfg_t;

    typedef struct packed {
        logic [15:0] run_packets;
        logic [31:0] run_bytes;
        logic [31:0] total_bulks;
        logic [31:0] total_bulk_packets;
        logic [39:0] total_bulk_bytes;
        logic [47:0] total_bulk_time;
    } fbt_cnt_t;

    localparam int unsigned FIELD_TS_BITS = 48;

    localparam logic [0:0] REG_IDLE_LIMIT = 1'b0;
    localparam logic [0:0] REG_MIN_BULK   = 1'b1;

    localparam logic [31:0] IDLE_LIMIT_RST = 32'd1000000;
    localparam logic [7:0]  MIN_BULK_RST   = 8'd4;
    localparam logic [7:0]  MIN_NEED       = 8'd2;

endpackage

// File: rtl/core/fbt_apb_regs.sv
// APB-style configuration registers of the flow bulk transfer tracker:
// idle limit and minimum bulk packet count, with read back.
// Depends on fbt_pkg.
module fbt_apb_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output fbt_pkg::fbt_cfg_t cfg
);
    import fbt_pkg::*;

    logic [31:0] idle_limit_reg;
    logic [7:0]  min_bulk_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg <= IDLE_LIMIT_RST;
            min_bulk_reg   <= MIN_BULK_RST;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_IDLE_LIMIT: idle_limit_reg <= pwdata;
                REG_MIN_BULK:   min_bulk_reg   <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_IDLE_LIMIT: prdata = idle_limit_reg;
            REG_MIN_BULK:   prdata = {24'd0, min_bulk_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.idle_limit       = idle_limit_reg;
    assign cfg.min_bulk_packets = min_bulk_reg;

endmodule

// File: rtl/core/fbt_step_logic.sv
// Per-packet update of one direction's run and bulk totals, with the drop
// check against the other direction, and the result beat it produces.
// Depends on fbt_pkg.
module fbt_step_logic #(
    parameter int unsigned TS_W = 48
) (
    input  fbt_pkg::fbt_in_t  beat,
    input  fbt_pkg::fbt_cfg_t cfg,
    input  logic [TS_W-1:0]   start_d,
    input  logic [TS_W-1:0]   last_d,
    input  logic [TS_W-1:0]   last_o,
    input  fbt_pkg::fbt_cnt_t cnt_d,
    output logic [TS_W-1:0]   start_n,
    output logic [TS_W-1:0]   last_n,
    output fbt_pkg::fbt_cnt_t cnt_n,
    output fbt_pkg::fbt_out_t result
);
    import fbt_pkg::*;

    logic [TS_W-1:0] ts;
    logic [TS_W-1:0] rs;
    logic [TS_W-1:0] gap;
    logic [TS_W-1:0] span_start;
    logic [TS_W-1:0] span_last;
    logic [TS_W-1:0] tt_add;
    logic [7:0]      need;
    logic            restart;
    logic            first;
    logic            more;
    logic [16:0]     pk_sum;
    logic [15:0]     pk_inc;
    logic [32:0]     by_sum;
    logic [31:0]     by_inc;
    logic [32:0]     bk_sum;
    logic [31:0]     pp_add;
    logic [32:0]     pp_sum;
    logic [39:0]     bb_add;
    logic [40:0]     bb_sum;
    logic [48:0]     tt_sum;

    always_comb
    begin
        ts      = beat.timestamp[TS_W-1:0];
        need    = (cfg.min_bulk_packets < MIN_NEED) ? MIN_NEED : cfg.min_bulk_packets;
        rs      = (last_o > start_d) ? '0 : start_d;
        gap     = ts - last_d;
        restart = (rs == '0) || ((ts >= last_d) && (gap > TS_W'(cfg.idle_limit)));

        pk_sum = {1'b0, cnt_d.run_packets} + 17'd1;
        pk_inc = pk_sum[16] ? '1 : pk_sum[15:0];
        by_sum = 33'(cnt_d.run_bytes) + 33'(beat.payload_bytes);
        by_inc = by_sum[32] ? '1 : by_sum[31:0];

        span_start = (ts > rs) ? (ts - rs) : '0;
        span_last  = (ts > last_d) ? (ts - last_d) : '0;
        first      = (pk_inc == 16'(need));
        more       = (pk_inc > 16'(need));

        bk_sum = 33'(cnt_d.total_bulks) + 33'd1;
        pp_add = first ? 32'(pk_inc) : 32'd1;
        pp_sum = 33'(cnt_d.total_bulk_packets) + 33'(pp_add);
        bb_add = first ? 40'(by_inc) : 40'(beat.payload_bytes);
        bb_sum = 41'(cnt_d.total_bulk_bytes) + 41'(bb_add);
        tt_add = first ? span_start : span_last;
        tt_sum = 49'(cnt_d.total_bulk_time) + 49'(tt_add);

        start_n = rs;
        last_n  = last_d;
        cnt_n   = cnt_d;

        if (beat.payload_bytes != 16'd0)
        begin
            if (restart)
            begin
                start_n           = ts;
                last_n            = ts;
                cnt_n.run_packets = 16'd1;
                cnt_n.run_bytes   = 32'(beat.payload_bytes);
            end
            else
            begin
                cnt_n.run_packets = pk_inc;
                cnt_n.run_bytes   = by_inc;
                if (first)
                begin
                    cnt_n.total_bulks = bk_sum[32] ? '1 : bk_sum[31:0];
                end
                if (first || more)
                begin
                    cnt_n.total_bulk_packets = pp_sum[32] ? '1 : pp_sum[31:0];
                    cnt_n.total_bulk_bytes   = bb_sum[40] ? '1 : bb_sum[39:0];
                    cnt_n.total_bulk_time    = tt_sum[48] ? '1 : tt_sum[47:0];
                end
                last_n = ts;
            end
        end

        result.direction_out = beat.direction;
        result.bulks_done    = cnt_n.total_bulks;
        result.bulk_packets  = cnt_n.total_bulk_packets;
        result.bulk_bytes    = cnt_n.total_bulk_bytes;
        result.bulk_time     = cnt_n.total_bulk_time;
        result.in_bulk       = (start_n != '0) && (cnt_n.run_packets >= 16'(need));
    end

endmodule

// File: rtl/core/flow_bulk_transfer_tracker_unit.sv
// Top level of the flow bulk transfer tracker: input register, per-direction
// run and bulk state, result register and configuration port.
// Depends on fbt_pkg, fbt_apb_regs and fbt_step_logic.
//
// Packets of one flow enter on the pkt channel as beats of direction,
// timestamp and payload length; every packet yields one result beat on the
// res channel with the updated bulk totals of its direction. Both channels
// use valid and ready. A packet is captured in the input register; once the
// result register is empty or being read, the step logic reads and updates
// the state of its direction while the result is written to the result
// register. One packet is taken every cycle while res_ready stays high, and
// each packet sees the state its direction was left in by the one before.
// When res_ready is low the result register holds its beat, the input
// register can still take one more packet, and pkt_ready then drops until
// the result is taken. Reset clears all run and total state to zero and
// loads the idle limit and minimum bulk size with 1000000 and 4. The user
// must write configuration through the APB-style port only while no packet
// is in flight; the block itself does not enforce it.
module flow_bulk_transfer_tracker_unit #(
    parameter int unsigned TIME_BITS = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pkt_valid,
    output logic             pkt_ready,
    input  fbt_pkg::fbt_in_t pkt,
    output logic             res_valid,
    input  logic             res_ready,
    output fbt_pkg::fbt_out_t res,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import fbt_pkg::*;

    localparam int unsigned TS_W = (TIME_BITS < FIELD_TS_BITS) ? TIME_BITS : FIELD_TS_BITS;

    fbt_cfg_t        cfg;
    logic            s1_valid_reg;
    fbt_in_t         s1_reg;
    logic            res_valid_reg;
    fbt_out_t        res_reg;
    logic [TS_W-1:0] start_reg [2];
    logic [TS_W-1:0] last_reg [2];
    fbt_cnt_t        cnt_reg [2];
    logic            dir_d;
    logic            dir_o;
    logic            s1_adv;
    logic [TS_W-1:0] start_next;
    logic [TS_W-1:0] last_next;
    fbt_cnt_t        cnt_next;
    fbt_out_t        res_next;

    fbt_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign dir_d     = s1_reg.direction;
    assign dir_o     = ~s1_reg.direction;
    assign s1_adv    = s1_valid_reg && (!res_valid_reg || res_ready);
    assign pkt_ready = !s1_valid_reg || s1_adv;

    fbt_step_logic #(
        .TS_W (TS_W)
    ) u_step (
        .beat    (s1_reg),
        .cfg     (cfg),
        .start_d (start_reg[dir_d]),
        .last_d  (last_reg[dir_d]),
        .last_o  (last_reg[dir_o]),
        .cnt_d   (cnt_reg[dir_d]),
        .start_n (start_next),
        .last_n  (last_next),
        .cnt_n   (cnt_next),
        .result  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                start_reg[i] <= '0;
                last_reg[i]  <= '0;
                cnt_reg[i]   <= '0;
            end
        end
        else
        begin
            if (pkt_ready)
            begin
                s1_valid_reg <= pkt_valid;
            end
            if (s1_adv)
            begin
                res_valid_reg    <= 1'b1;
                start_reg[dir_d] <= start_next;
                last_reg[dir_d]  <= last_next;
                cnt_reg[dir_d]   <= cnt_next;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_valid && pkt_ready)
        begin
            s1_reg <= pkt;
        end
        if (s1_adv)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> pkt_ready)
        else $error("Input not ready while the result register is empty.");

    a_block_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && res_valid_reg && !res_ready) |-> !pkt_ready)
        else $error("Input ready while both stages are full and stalled.");

    a_adv_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> res_valid_reg)
        else $error("A processed beat did not reach the result register.");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_ready && !s1_valid_reg) |=> !res_valid_reg)
        else $error("Result register stayed valid after its beat was taken.");

endmodule

// File: sim/fbt_bulk_checker.sv
`timescale 1ns / 1ps
// Checker for the flow bulk transfer tracker: follows the register writes, predicts the
// totals beat of every accepted packet and compares it with the result beats.
// Depends on fbt_pkg.
module fbt_bulk_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pkt_valid,
    input  logic                pkt_ready,
    input  fbt_pkg::fbt_in_t    pkt,
    input  logic                res_valid,
    input  logic                res_ready,
    input  fbt_pkg::fbt_out_t   res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output int                  fail_count,
    output int                  pending
);
    import fbt_pkg::*;

    logic [31:0] idle_limit_q;
    logic [7:0]  min_bulk_q;

    logic [47:0] open_start [2];
    logic [47:0] open_last  [2];
    logic [15:0] open_pkts  [2];
    logic [31:0] open_bytes [2];
    logic [31:0] sum_bulks  [2];
    logic [31:0] sum_pkts   [2];
    logic [39:0] sum_bytes  [2];
    logic [47:0] sum_time   [2];

    fbt_out_t totals_due [$];

    function automatic logic [63:0] clamp_add(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] top);
        return (a + b > top) ? top : a + b;
    endfunction

    function automatic logic [63:0] elapsed(input logic [63:0] t, input logic [63:0] from);
        return (t > from) ? t - from : 64'd0;
    endfunction

    function automatic fbt_out_t bulk_totals_after(input fbt_in_t p);
        logic        d;
        logic        o;
        logic [63:0] ts;
        logic [63:0] size;
        logic [63:0] need;
        fbt_out_t    r;
        d    = p.direction;
        o    = ~p.direction;
        ts   = 64'(p.timestamp);
        size = 64'(p.payload_bytes);
        need = (min_bulk_q < MIN_NEED) ? 64'(MIN_NEED) : 64'(min_bulk_q);

        // A run is void once the other direction has been active after it began.
        if (open_last[o] > open_start[d])
            open_start[d] = '0;

        if (size != 0)
        begin
            if (open_start[d] == 0 ||
                (ts >= 64'(open_last[d]) && ts - 64'(open_last[d]) > 64'(idle_limit_q)))
            begin
                open_start[d] = ts[47:0];
                open_last[d]  = ts[47:0];
                open_pkts[d]  = 16'd1;
                open_bytes[d] = size[31:0];
            end
            else
            begin
                open_pkts[d]  = 16'(clamp_add(64'(open_pkts[d]), 64'd1, 64'hFFFF));
                open_bytes[d] = 32'(clamp_add(64'(open_bytes[d]), size, 64'hFFFF_FFFF));
                if (64'(open_pkts[d]) == need)
                begin
                    sum_bulks[d] = 32'(clamp_add(64'(sum_bulks[d]), 64'd1, 64'hFFFF_FFFF));
                    sum_pkts[d]  = 32'(clamp_add(64'(sum_pkts[d]), 64'(open_pkts[d]),
                                                 64'hFFFF_FFFF));
                    sum_bytes[d] = 40'(clamp_add(64'(sum_bytes[d]), 64'(open_bytes[d]),
                                                 64'hFF_FFFF_FFFF));
                    sum_time[d]  = 48'(clamp_add(64'(sum_time[d]),
                                                 elapsed(ts, 64'(open_start[d])),
                                                 64'hFFFF_FFFF_FFFF));
                end
                else if (64'(open_pkts[d]) > need)
                begin
                    sum_pkts[d]  = 32'(clamp_add(64'(sum_pkts[d]), 64'd1, 64'hFFFF_FFFF));
                    sum_bytes[d] = 40'(clamp_add(64'(sum_bytes[d]), size, 64'hFF_FFFF_FFFF));
                    sum_time[d]  = 48'(clamp_add(64'(sum_time[d]),
                                                 elapsed(ts, 64'(open_last[d])),
                                                 64'hFFFF_FFFF_FFFF));
                end
                open_last[d] = ts[47:0];
            end
        end

        r.direction_out = d;
        r.bulks_done    = sum_bulks[d];
        r.bulk_packets  = sum_pkts[d];
        r.bulk_bytes    = sum_bytes[d];
        r.bulk_time     = sum_time[d];
        r.in_bulk       = (open_start[d] != 0 && 64'(open_pkts[d]) >= need);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (fail_count < 10)
            $display("%0t: result beat mismatch on %s: expected %0h, got %0h",
                     $time, what, want, got);
        fail_count++;
    endtask

    task automatic compare_field(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
            note_mismatch(what, want, got);
    endtask

    always @(posedge clk)
    begin
        fbt_out_t want;
        if (!rst_n)
        begin
            idle_limit_q = IDLE_LIMIT_RST;
            min_bulk_q   = MIN_BULK_RST;
            for (int i = 0; i < 2; i++)
            begin
                open_start[i] = '0;
                open_last[i]  = '0;
                open_pkts[i]  = '0;
                open_bytes[i] = '0;
                sum_bulks[i]  = '0;
                sum_pkts[i]   = '0;
                sum_bytes[i]  = '0;
                sum_time[i]   = '0;
            end
            totals_due.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
            begin
                if (paddr[2] == REG_IDLE_LIMIT)
                    idle_limit_q = pwdata;
                else if (paddr[2] == REG_MIN_BULK)
                    min_bulk_q = pwdata[7:0];
            end
            if (pkt_valid && pkt_ready)
                totals_due = {totals_due, bulk_totals_after(pkt)};
            if (res_valid && res_ready)
            begin
                if (totals_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result beat with nothing expected: %h", $time, res);
                    fail_count++;
                end
                else
                begin
                    want = totals_due.pop_front();
                    compare_field("direction_out", 64'(want.direction_out),
                                  64'(res.direction_out));
                    compare_field("bulks_done", 64'(want.bulks_done), 64'(res.bulks_done));
                    compare_field("bulk_packets", 64'(want.bulk_packets),
                                  64'(res.bulk_packets));
                    compare_field("bulk_bytes", 64'(want.bulk_bytes), 64'(res.bulk_bytes));
                    compare_field("bulk_time", 64'(want.bulk_time), 64'(res.bulk_time));
                    compare_field("in_bulk", 64'(want.in_bulk), 64'(res.in_bulk));
                end
            end
            pending = totals_due.size();
        end
    end

endmodule

// File: sim/flow_bulk_transfer_tracker_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the flow bulk transfer tracker: clock, reset, packet and register
// stimulus with random pauses on both channels, and the final verdict.
// Depends on fbt_pkg, flow_bulk_transfer_tracker_unit and fbt_bulk_checker.
module flow_bulk_transfer_tracker_unit_tb;
    import fbt_pkg::*;

    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_BWD = 1'b1;
    localparam logic [47:0] TS_MAX = 48'hFFFF_FFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        pkt_valid;
    logic        pkt_ready;
    fbt_in_t     pkt;
    logic        res_valid;
    logic        res_ready;
    fbt_out_t    res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    bit          steady;
    logic [47:0] now;

    flow_bulk_transfer_tracker_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    fbt_bulk_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_valid  (pkt_valid),
        .pkt_ready  (pkt_ready),
        .pkt        (pkt),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int pause_len();
        if (steady)
            return 0;
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic fbt_in_t pkt_beat(input logic d, input logic [47:0] ts,
                                         input logic [15:0] sz);
        fbt_in_t p;
        p.direction     = d;
        p.timestamp     = ts;
        p.payload_bytes = sz;
        return p;
    endfunction

    task automatic send_packet(input fbt_in_t p);
        int gap;
        gap = pause_len();
        if (gap > 0)
        begin
            pkt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pkt       <= p;
        pkt_valid <= 1'b1;
        @(posedge clk);
        while (!pkt_ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        pkt_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [0:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly runs of one direction with random content and some empty payloads;
    // dirty runs also carry other-direction beats, idle gaps and time jumps.
    task automatic traffic(input logic [31:0] idle, input logic [7:0] minb, input int quota);
        int          sent;
        int          len;
        int          r;
        int          need;
        int          cap;
        bit          d;
        bit          clean;
        logic        pd;
        logic [47:0] ts;
        logic [15:0] sz;
        need = (minb < 2) ? 2 : minb;
        cap  = (idle < 1000) ? idle : 1000;
        sent = 0;
        while (sent < quota)
        begin
            d      = 1'($urandom_range(0, 1));
            clean  = ($urandom_range(0, 1) == 0);
            steady = ($urandom_range(0, 5) == 0);
            len    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, need)
                                                 : need + $urandom_range(0, 8);
            for (int k = 0; k < len && sent < quota; k++)
            begin
                r = $urandom_range(0, 99);
                if (clean && r >= 5 && r < 17)
                    r = 99;
                pd = d;
                sz = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 255))
                                                 : 16'($urandom_range(1, 65535));
                if (r < 11 && r >= 9)
                    now = now + 48'(idle) + 48'd1 + 48'($urandom_range(0, 50));
                else if (r < 13 && r >= 11)
                    now = now + 48'(idle);
                else if (r == 16)
                    now = 48'({$urandom, $urandom});
                else if (r >= 17 || r < 9)
                    now = now + 48'($urandom_range(0, cap));
                ts = now;
                if (r < 5)
                    sz = '0;
                else if (r < 9)
                    pd = ~d;
                else if (r < 15 && r >= 13)
                    ts = now - 48'($urandom_range(1, 100));
                else if (r == 15)
                    ts = '0;
                send_packet(pkt_beat(pd, ts, sz));
                sent++;
            end
        end
    endtask

    initial
    begin
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            int gap;
            gap = pause_len();
            if (gap > 0)
            begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        logic [31:0] idle;
        logic [7:0]  minb;
        int          quota;
        rst_n     = 1'b0;
        pkt_valid = 1'b0;
        pkt       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        steady    = 1'b0;
        now       = 48'd5000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under the reset settings of the two registers.
        send_packet(pkt_beat(DIR_FWD, 48'd0, 16'd100));
        send_packet(pkt_beat(DIR_FWD, 48'd10, 16'd100));
        send_packet(pkt_beat(DIR_FWD, 48'd20, 16'd0));
        send_packet(pkt_beat(DIR_FWD, 48'd30, 16'hFFFF));
        send_packet(pkt_beat(DIR_FWD, 48'd40, 16'd1));
        send_packet(pkt_beat(DIR_FWD, 48'd50, 16'd7));
        send_packet(pkt_beat(DIR_FWD, 48'd45, 16'd9));
        send_packet(pkt_beat(DIR_FWD, 48'd1000045, 16'd3));
        send_packet(pkt_beat(DIR_FWD, 48'd2000047, 16'd3));
        send_packet(pkt_beat(DIR_BWD, 48'd2000100, 16'd500));
        send_packet(pkt_beat(DIR_FWD, 48'd2000200, 16'd4));
        send_packet(pkt_beat(DIR_BWD, TS_MAX, 16'hFFFF));
        send_packet(pkt_beat(DIR_BWD, TS_MAX, 16'd1));
        send_packet(pkt_beat(DIR_BWD, TS_MAX, 16'd1));
        send_packet(pkt_beat(DIR_BWD, TS_MAX, 16'd1));
        send_packet(pkt_beat(DIR_BWD, TS_MAX, 16'd0));
        send_packet(pkt_beat(DIR_FWD, 48'h8000_0000_0000, 16'hAAAA));
        send_packet(pkt_beat(DIR_FWD, 48'h8000_0000_0001, 16'h5555));
        send_packet(pkt_beat(DIR_FWD, 48'h8000_0000_0002, 16'h0001));
        send_packet(pkt_beat(DIR_BWD, 48'h0000_0000_0001, 16'h0001));

        for (int ph = 0; ph < 8; ph++)
        begin
            quota = 130;
            case (ph)
                0:       begin idle = 32'd1000;       minb = 8'd2;   end
                1:       begin idle = 32'd0;          minb = 8'd0;   end
                2:       begin idle = 32'hFFFF_FFFF;  minb = 8'd255; quota = 540; end
                3:       begin idle = 32'd50;         minb = 8'd1;   end
                4:       begin idle = $urandom_range(1, 20000);
                               minb = 8'($urandom_range(3, 12)); end
                5:       begin idle = 32'd1000000;    minb = 8'd6;   end
                6:       begin idle = 32'd1;          minb = 8'd3;   end
                default: begin idle = 32'hFFFF_FFFF;  minb = 8'd2;   end
            endcase
            wait_idle();
            apb_write(REG_IDLE_LIMIT, idle);
            apb_write(REG_MIN_BULK, {24'd0, minb});
            traffic(idle, minb, quota);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[flow_bulk_transfer_tracker_unit] OK");
        else
            $display("[flow_bulk_transfer_tracker_unit] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[flow_bulk_transfer_tracker_unit] ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/fbt_pkg.sv
rtl/core/fbt_apb_regs.sv
rtl/core/fbt_step_logic.sv
rtl/core/flow_bulk_transfer_tracker_unit.sv
sim/fbt_bulk_checker.sv
sim/flow_bulk_transfer_tracker_unit_tb.sv
